@@ rtl/vn_pkg.sv @@
package vn_pkg;

	// field widths
	localparam int COMP_W     = 24;
	localparam int SQ_W       = 2 * COMP_W;
	localparam int ROOT_W     = COMP_W;
	localparam int UNIT_SHIFT = 14;
	localparam int QUO_W      = UNIT_SHIFT + 1;
	localparam int UNIT_W     = 16;
	localparam int LANES      = 3;

	// pipeline depths
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = QUO_W;

	// one component as sign and absolute value
	typedef struct packed {
		logic              neg;
		logic [COMP_W-1:0] mag;
	} comp_t;

	typedef comp_t [LANES-1:0] vec_t;

endpackage

@@ rtl/vn_square.sv @@
module vn_square (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [vn_pkg::COMP_W-1:0] in_x,
	input  logic signed [vn_pkg::COMP_W-1:0] in_y,
	input  logic signed [vn_pkg::COMP_W-1:0] in_z,
	output logic                             out_valid,
	output logic [vn_pkg::SQ_W-1:0]          out_sum,
	output vn_pkg::vec_t                     out_vec
);

	logic                    valid_s1, valid_s2, valid_s3;
	vn_pkg::vec_t            vec_s1, vec_s2, vec_s3;
	vn_pkg::vec_t            vec_in;
	logic [vn_pkg::SQ_W-1:0] sq_s2 [vn_pkg::LANES];
	logic [vn_pkg::SQ_W-1:0] sum_s3;

	// sign and absolute value of each component
	function automatic vn_pkg::comp_t split_comp(input logic [vn_pkg::COMP_W-1:0] c);
		vn_pkg::comp_t r;
		r.neg = c[vn_pkg::COMP_W-1];
		r.mag = r.neg ? (~c + vn_pkg::COMP_W'(1)) : c;
		return r;
	endfunction

	assign vec_in[0] = split_comp(in_x);
	assign vec_in[1] = split_comp(in_y);
	assign vec_in[2] = split_comp(in_z);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1 absolute values, stage 2 squares, stage 3 sum
	always_ff @(posedge clk) begin
		vec_s1 <= vec_in;
		vec_s2 <= vec_s1;
		vec_s3 <= vec_s2;
		for (int i = 0; i < vn_pkg::LANES; i++) begin
			sq_s2[i] <= {{vn_pkg::COMP_W{1'b0}}, vec_s1[i].mag}
				* {{vn_pkg::COMP_W{1'b0}}, vec_s1[i].mag};
		end
		sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	assign out_valid = valid_s3;
	assign out_sum   = sum_s3;
	assign out_vec   = vec_s3;

endmodule

@@ rtl/vn_sqrt.sv @@
module vn_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [vn_pkg::SQ_W-1:0]   in_sum,
	input  vn_pkg::vec_t              in_vec,
	output logic                      out_valid,
	output logic [vn_pkg::ROOT_W-1:0] out_root,
	output vn_pkg::vec_t              out_vec
);

	localparam int N = vn_pkg::SQRT_STEPS;

	logic                    valid_s [0:N];
	logic [vn_pkg::SQ_W-1:0] rem_s   [0:N];
	logic [vn_pkg::SQ_W-1:0] root_s  [0:N];
	vn_pkg::vec_t            vec_s   [0:N];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = in_sum;
	assign root_s[0]  = '0;
	assign vec_s[0]   = in_vec;

	// one result bit per stage, most significant first
	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [vn_pkg::SQ_W-1:0] BIT =
			vn_pkg::SQ_W'(1) << (vn_pkg::SQ_W - 2 - 2 * k);

		logic [vn_pkg::SQ_W-1:0] trial;
		logic                    take;

		assign trial = root_s[k] + BIT;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			vec_s[k+1] <= vec_s[k];
			if (take) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_root  = root_s[N][vn_pkg::ROOT_W-1:0];
	assign out_vec   = vec_s[N];

endmodule

@@ rtl/vn_div.sv @@
module vn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [vn_pkg::ROOT_W-1:0] in_len,
	input  vn_pkg::vec_t              in_vec,
	output logic                      out_valid,
	output logic [vn_pkg::ROOT_W-1:0] out_len,
	output logic [vn_pkg::LANES-1:0]  out_neg,
	output logic [vn_pkg::QUO_W-1:0]  out_quo [vn_pkg::LANES]
);

	localparam int N  = vn_pkg::DIV_STEPS;
	localparam int PW = vn_pkg::ROOT_W + 1;
	localparam int L  = vn_pkg::LANES;

	logic                      valid_s [0:N];
	logic [vn_pkg::ROOT_W-1:0] len_s   [0:N];
	logic [L-1:0]              neg_s   [0:N];
	logic [PW-1:0]             part_s  [0:N][L];
	logic [vn_pkg::QUO_W-1:0]  quo_s   [0:N][L];

	assign valid_s[0] = in_valid;
	assign len_s[0]   = in_len;

	// partial remainder starts at the absolute component
	for (genvar i = 0; i < L; i++) begin : g_init
		assign neg_s[0][i]  = in_vec[i].neg;
		assign part_s[0][i] = {1'b0, in_vec[i].mag};
		assign quo_s[0][i]  = '0;
	end

	// restoring division, one quotient bit per stage for all three lanes
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [PW-1:0] diff [L];
		logic [L-1:0]  take;

		for (genvar i = 0; i < L; i++) begin : g_lane
			assign take[i] = part_s[k][i] >= {1'b0, len_s[k]};
			assign diff[i] = take[i] ? (part_s[k][i] - {1'b0, len_s[k]}) : part_s[k][i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			len_s[k+1] <= len_s[k];
			neg_s[k+1] <= neg_s[k];
			for (int i = 0; i < L; i++) begin
				part_s[k+1][i] <= {diff[i][PW-2:0], 1'b0};
				quo_s[k+1][i]  <= {quo_s[k][i][vn_pkg::QUO_W-2:0], take[i]};
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_len   = len_s[N];
	assign out_neg   = neg_s[N];
	assign out_quo   = quo_s[N];

endmodule

@@ rtl/vector3_normalize_top.sv @@
// vector3_normalize_top: length and unit vector of a three-component vector
//
// input: drive comp_x, comp_y, comp_z (signed, 12 fraction bits) and pulse
// start; a word is taken at each rising edge with start high and busy low.
// busy stays low, so a new word may be given in every cycle.
// output: done is high for exactly one cycle per input word, with magnitude
// (unsigned, 12 fraction bits, rounded down), unit_x/y/z (16384 = 1.0,
// truncated toward zero) and zero_vector on the ports in that cycle.
// A zero vector gives magnitude 0, zero unit components and zero_vector set.
// pipeline: each word passes in order through three stages that form the sum
// of squares, 24 stages that take the square root one bit each, 15 stages
// that divide the three lanes one quotient bit each, and one output register.
// Throughput is one word per clock, set by the fully pipelined root and
// divide stages.
// reset: arst_n low clears all valid bits at once, dropping words in flight;
// done is low until new words have passed through.
// the receiver has no way to stall; results are never held back.
module vector3_normalize_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [vn_pkg::COMP_W-1:0]  comp_x,
	input  logic signed [vn_pkg::COMP_W-1:0]  comp_y,
	input  logic signed [vn_pkg::COMP_W-1:0]  comp_z,
	output logic                              done,
	output logic [vn_pkg::ROOT_W-1:0]         magnitude,
	output logic signed [vn_pkg::UNIT_W-1:0]  unit_x,
	output logic signed [vn_pkg::UNIT_W-1:0]  unit_y,
	output logic signed [vn_pkg::UNIT_W-1:0]  unit_z,
	output logic                              zero_vector
);

	logic                      sq_valid;
	logic [vn_pkg::SQ_W-1:0]   sq_sum;
	vn_pkg::vec_t              sq_vec;
	logic                      rt_valid;
	logic [vn_pkg::ROOT_W-1:0] rt_root;
	vn_pkg::vec_t              rt_vec;
	logic                      dv_valid;
	logic [vn_pkg::ROOT_W-1:0] dv_len;
	logic [vn_pkg::LANES-1:0]  dv_neg;
	logic [vn_pkg::QUO_W-1:0]  dv_quo [vn_pkg::LANES];
	logic [vn_pkg::UNIT_W-1:0] unit   [vn_pkg::LANES];
	logic                      dv_zero;

	logic                      done_q;
	logic [vn_pkg::ROOT_W-1:0] magnitude_q;
	logic [vn_pkg::UNIT_W-1:0] unit_q [vn_pkg::LANES];
	logic                      zero_q;

	// fully pipelined, never stalls
	assign busy = 1'b0;

	vn_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_x      (comp_x),
		.in_y      (comp_y),
		.in_z      (comp_z),
		.out_valid (sq_valid),
		.out_sum   (sq_sum),
		.out_vec   (sq_vec)
	);

	vn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_sum    (sq_sum),
		.in_vec    (sq_vec),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_vec   (rt_vec)
	);

	vn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.in_len    (rt_root),
		.in_vec    (rt_vec),
		.out_valid (dv_valid),
		.out_len   (dv_len),
		.out_neg   (dv_neg),
		.out_quo   (dv_quo)
	);

	// sign restore, zero length forces zero components
	assign dv_zero = (dv_len == '0);

	for (genvar i = 0; i < vn_pkg::LANES; i++) begin : g_unit
		logic [vn_pkg::UNIT_W-1:0] quo_ext;
		assign quo_ext = {{(vn_pkg::UNIT_W - vn_pkg::QUO_W){1'b0}}, dv_quo[i]};
		assign unit[i] = dv_zero ? '0 : (dv_neg[i] ? (~quo_ext + vn_pkg::UNIT_W'(1)) : quo_ext);
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		magnitude_q <= dv_len;
		unit_q      <= unit;
		zero_q      <= dv_zero;
	end

	assign done        = done_q;
	assign magnitude   = magnitude_q;
	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];
	assign zero_vector = zero_q;

endmodule
